FILE: hdl/btcc_pkg.sv
// Shared types and constants for the battery thermal charge control block.
// Used by every module in hdl/. Has no dependencies of its own.
`default_nettype none

package btcc_pkg;

	localparam int TEMP_W  = 8;
	localparam int VOLT_W  = 23;
	localparam int CUR_W   = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_COLD_STOP_MAX = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COOL_MAX      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_MAX    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WARM_MAX      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HOT_MAX       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HOT_VOLT      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_REDUCED_CUR   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_CUR   = 3'd7;

	localparam logic signed [TEMP_W-1:0] RST_COLD_STOP_MAX = -8'sd11;
	localparam logic signed [TEMP_W-1:0] RST_COOL_MAX      = -8'sd5;
	localparam logic signed [TEMP_W-1:0] RST_NORMAL_MAX    = 8'sd41;
	localparam logic signed [TEMP_W-1:0] RST_WARM_MAX      = 8'sd45;
	localparam logic signed [TEMP_W-1:0] RST_HOT_MAX       = 8'sd55;
	localparam logic [VOLT_W-1:0] RST_HOT_VOLT    = 23'd4000000;
	localparam logic [CUR_W-1:0]  RST_REDUCED_CUR = 12'd450;
	localparam logic [CUR_W-1:0]  RST_DEFAULT_CUR = 12'd1000;

	typedef enum logic [2:0] {
		BAND_COLD   = 3'd0,
		BAND_COOL   = 3'd1,
		BAND_NORMAL = 3'd2,
		BAND_WARM   = 3'd3,
		BAND_HOT    = 3'd4,
		BAND_ABOVE  = 3'd5
	} band_t;

	typedef enum logic [1:0] {
		ST_NORMAL  = 2'd0,
		ST_REDUCED = 2'd1,
		ST_STOPPED = 2'd2
	} mode_t;

	localparam logic [2:0] CODE_NONE           = 3'd0;
	localparam logic [2:0] CODE_NORMAL_STOP    = 3'd1;
	localparam logic [2:0] CODE_NORMAL_REDUCED = 3'd2;
	localparam logic [2:0] CODE_REDUCED_STOP   = 3'd3;
	localparam logic [2:0] CODE_REDUCED_NORMAL = 3'd4;
	localparam logic [2:0] CODE_STOP_NORMAL    = 3'd5;

	localparam logic [1:0] HEALTH_GOOD     = 2'd0;
	localparam logic [1:0] HEALTH_OVERHEAT = 2'd1;
	localparam logic [1:0] HEALTH_COLD     = 2'd2;

	typedef struct packed {
		logic signed [TEMP_W-1:0] cold_stop_max_c;
		logic signed [TEMP_W-1:0] cool_max_c;
		logic signed [TEMP_W-1:0] normal_max_c;
		logic signed [TEMP_W-1:0] warm_max_c;
		logic signed [TEMP_W-1:0] hot_max_c;
		logic [VOLT_W-1:0]        hot_volt_limit_uv;
		logic [CUR_W-1:0]         reduced_current_ma;
		logic [CUR_W-1:0]         default_current_ma;
	} cfg_t;

	// classified tick, as queued between front and back
	typedef struct packed {
		logic             charger;
		band_t            band;
		logic             vhigh;
		logic [CUR_W-1:0] cur_normal;
		logic [CUR_W-1:0] cur_reduced;
		logic [CUR_W-1:0] cur_stopped;
	} item_t;

	typedef struct packed {
		mode_t            charge_state;
		logic [2:0]       change_code;
		logic             update_req;
		logic             disable_charge;
		logic [CUR_W-1:0] current_ma;
		logic [1:0]       health;
		logic             pseudo_charging_ui;
	} res_t;

endpackage

`default_nettype wire

FILE: hdl/battery_thermal_charge_control.sv
// Top level of the battery thermal charge control block: configuration
// registers, front classifier, tick queue and back end state machine.
// Depends on btcc_pkg, btcc_front, btcc_queue and btcc_back.
//
// One monitor tick in, one result out. A new tick is taken every cycle while
// the queue is not full; each accepted tick is held in the two-entry queue,
// then in the output register, which presents its result. When the output
// stalls the queue fills and in_ready drops after two more ticks. Config
// writes are taken every cycle (cfg_ready is always high) and must be done
// while idle.
`default_nettype none

module battery_thermal_charge_control (
	input  wire                                         clk,
	input  wire                                         arst_n,
	input  wire                                         in_valid,
	output logic                                        in_ready,
	input  wire                                         charger_present,
	input  wire logic signed [btcc_pkg::TEMP_W-1:0]     battery_temp_c,
	input  wire logic [btcc_pkg::VOLT_W-1:0]            battery_volt_uv,
	input  wire logic [btcc_pkg::CUR_W-1:0]             thermal_limit_ma,
	input  wire logic [btcc_pkg::CUR_W-1:0]             charger_limit_ma,
	output logic                                        out_valid,
	input  wire                                         out_ready,
	output logic [1:0]                                  charge_state,
	output logic [2:0]                                  change_code,
	output logic                                        update_req,
	output logic                                        disable_charge,
	output logic [btcc_pkg::CUR_W-1:0]                  current_ma,
	output logic [1:0]                                  health,
	output logic                                        pseudo_charging_ui,
	input  wire                                         cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [btcc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [btcc_pkg::CFG_DATA_W-1:0]        cfg_data
);

	btcc_pkg::cfg_t  cfg_q;
	btcc_pkg::item_t front_item;
	btcc_pkg::item_t head;
	btcc_pkg::res_t  res;
	logic            q_full;
	logic            q_valid;
	logic            pop;
	logic            push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cold_stop_max_c    <= btcc_pkg::RST_COLD_STOP_MAX;
			cfg_q.cool_max_c         <= btcc_pkg::RST_COOL_MAX;
			cfg_q.normal_max_c       <= btcc_pkg::RST_NORMAL_MAX;
			cfg_q.warm_max_c         <= btcc_pkg::RST_WARM_MAX;
			cfg_q.hot_max_c          <= btcc_pkg::RST_HOT_MAX;
			cfg_q.hot_volt_limit_uv  <= btcc_pkg::RST_HOT_VOLT;
			cfg_q.reduced_current_ma <= btcc_pkg::RST_REDUCED_CUR;
			cfg_q.default_current_ma <= btcc_pkg::RST_DEFAULT_CUR;
		end else if (cfg_valid) begin
			case (cfg_index)
				btcc_pkg::CFG_COLD_STOP_MAX: cfg_q.cold_stop_max_c    <= cfg_data[7:0];
				btcc_pkg::CFG_COOL_MAX:      cfg_q.cool_max_c         <= cfg_data[7:0];
				btcc_pkg::CFG_NORMAL_MAX:    cfg_q.normal_max_c       <= cfg_data[7:0];
				btcc_pkg::CFG_WARM_MAX:      cfg_q.warm_max_c         <= cfg_data[7:0];
				btcc_pkg::CFG_HOT_MAX:       cfg_q.hot_max_c          <= cfg_data[7:0];
				btcc_pkg::CFG_HOT_VOLT:      cfg_q.hot_volt_limit_uv  <= cfg_data;
				btcc_pkg::CFG_REDUCED_CUR:   cfg_q.reduced_current_ma <= cfg_data[11:0];
				btcc_pkg::CFG_DEFAULT_CUR:   cfg_q.default_current_ma <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	btcc_front u_front (
		.cfg              (cfg_q),
		.charger_present  (charger_present),
		.battery_temp_c   (battery_temp_c),
		.battery_volt_uv  (battery_volt_uv),
		.thermal_limit_ma (thermal_limit_ma),
		.charger_limit_ma (charger_limit_ma),
		.item             (front_item)
	);

	btcc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.head      (head)
	);

	btcc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign charge_state       = res.charge_state;
	assign change_code        = res.change_code;
	assign update_req         = res.update_req;
	assign disable_charge     = res.disable_charge;
	assign current_ma         = res.current_ma;
	assign health             = res.health;
	assign pseudo_charging_ui = res.pseudo_charging_ui;

endmodule

`default_nettype wire

FILE: hdl/btcc_front.sv
// Front end: sorts the temperature into a band, flags high voltage and
// precomputes the candidate currents. Depends on btcc_pkg.
`default_nettype none

module btcc_front (
	input  wire btcc_pkg::cfg_t                        cfg,
	input  wire                                        charger_present,
	input  wire logic signed [btcc_pkg::TEMP_W-1:0]    battery_temp_c,
	input  wire logic [btcc_pkg::VOLT_W-1:0]           battery_volt_uv,
	input  wire logic [btcc_pkg::CUR_W-1:0]            thermal_limit_ma,
	input  wire logic [btcc_pkg::CUR_W-1:0]            charger_limit_ma,
	output btcc_pkg::item_t                            item
);

	btcc_pkg::band_t band;

	always_comb begin
		if (battery_temp_c > cfg.hot_max_c) begin
			band = btcc_pkg::BAND_ABOVE;
		end else if (battery_temp_c > cfg.warm_max_c) begin
			band = btcc_pkg::BAND_HOT;
		end else if (battery_temp_c > cfg.normal_max_c) begin
			band = btcc_pkg::BAND_WARM;
		end else if (battery_temp_c > cfg.cool_max_c) begin
			band = btcc_pkg::BAND_NORMAL;
		end else if (battery_temp_c > cfg.cold_stop_max_c) begin
			band = btcc_pkg::BAND_COOL;
		end else begin
			band = btcc_pkg::BAND_COLD;
		end
	end

	always_comb begin
		item.charger     = charger_present;
		item.band        = band;
		item.vhigh       = battery_volt_uv > cfg.hot_volt_limit_uv;
		item.cur_normal  = (thermal_limit_ma <= charger_limit_ma) ?
			thermal_limit_ma : charger_limit_ma;
		item.cur_reduced = (thermal_limit_ma <= cfg.reduced_current_ma) ?
			thermal_limit_ma : cfg.reduced_current_ma;
		item.cur_stopped = cfg.default_current_ma;
	end

endmodule

`default_nettype wire

FILE: hdl/btcc_queue.sv
// Short FIFO of classified ticks between front and back.
// Depends on btcc_pkg for the item type and depth.
`default_nettype none

module btcc_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  wire btcc_pkg::item_t push_item,
	output logic                 full,
	input  wire                  pop,
	output logic                 not_empty,
	output btcc_pkg::item_t      head
);

	btcc_pkg::item_t                mem_q [btcc_pkg::QDEPTH];
	logic [btcc_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [btcc_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [btcc_pkg::QCNT_W-1:0]    count_q;

	localparam logic [btcc_pkg::QPTR_W-1:0] PTR_LAST =
		btcc_pkg::QPTR_W'(btcc_pkg::QDEPTH - 1);
	localparam logic [btcc_pkg::QCNT_W-1:0] CNT_FULL =
		btcc_pkg::QCNT_W'(btcc_pkg::QDEPTH);

	assign full      = count_q == CNT_FULL;
	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/btcc_back.sv
// Back end: charge mode state machine, current choice, update flag and the
// output register. Depends on btcc_pkg.
`default_nettype none

module btcc_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  q_valid,
	input  wire btcc_pkg::item_t head,
	output logic                 pop,
	output logic                 out_valid,
	input  wire                  out_ready,
	output btcc_pkg::res_t       res
);

	btcc_pkg::mode_t                 state_q;
	btcc_pkg::mode_t                 state_nx;
	btcc_pkg::mode_t                 st0;
	logic                            pseudo_q;
	logic                            pseudo_nx;
	logic                            last_chg_q;
	logic [btcc_pkg::CUR_W-1:0]      last_cur_q;
	logic [btcc_pkg::CUR_W-1:0]      cur;
	logic [2:0]                      code;
	logic                            plug;
	logic                            out_valid_q;
	btcc_pkg::res_t                  res_q;
	btcc_pkg::res_t                  res_nx;

	assign pop       = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		plug      = head.charger && !last_chg_q;
		st0       = plug ? btcc_pkg::ST_NORMAL : state_q;
		state_nx  = st0;
		pseudo_nx = pseudo_q;
		code      = btcc_pkg::CODE_NONE;
		case (st0)
			btcc_pkg::ST_NORMAL: begin
				if (head.band == btcc_pkg::BAND_ABOVE || head.band == btcc_pkg::BAND_COLD) begin
					code      = btcc_pkg::CODE_NORMAL_STOP;
					pseudo_nx = head.band == btcc_pkg::BAND_COLD;
					state_nx  = btcc_pkg::ST_STOPPED;
				end else if (head.band == btcc_pkg::BAND_HOT) begin
					if (head.vhigh) begin
						code      = btcc_pkg::CODE_NORMAL_STOP;
						pseudo_nx = 1'b1;
						state_nx  = btcc_pkg::ST_STOPPED;
					end else begin
						code      = btcc_pkg::CODE_NORMAL_REDUCED;
						pseudo_nx = 1'b0;
						state_nx  = btcc_pkg::ST_REDUCED;
					end
				end
			end
			btcc_pkg::ST_REDUCED: begin
				if (head.band == btcc_pkg::BAND_ABOVE || head.band == btcc_pkg::BAND_COLD) begin
					code      = btcc_pkg::CODE_REDUCED_STOP;
					pseudo_nx = head.band == btcc_pkg::BAND_COLD;
					state_nx  = btcc_pkg::ST_STOPPED;
				end else if (head.band == btcc_pkg::BAND_COOL ||
					head.band == btcc_pkg::BAND_NORMAL) begin
					code      = btcc_pkg::CODE_REDUCED_NORMAL;
					pseudo_nx = 1'b0;
					state_nx  = btcc_pkg::ST_NORMAL;
				end else if (head.vhigh) begin
					code      = btcc_pkg::CODE_REDUCED_STOP;
					pseudo_nx = 1'b1;
					state_nx  = btcc_pkg::ST_STOPPED;
				end
			end
			btcc_pkg::ST_STOPPED: begin
				if (head.band == btcc_pkg::BAND_NORMAL) begin
					code      = btcc_pkg::CODE_STOP_NORMAL;
					pseudo_nx = 1'b0;
					state_nx  = btcc_pkg::ST_NORMAL;
				end else if (head.band == btcc_pkg::BAND_ABOVE) begin
					pseudo_nx = 1'b0;
				end
			end
			default: begin
			end
		endcase

		case (state_nx)
			btcc_pkg::ST_NORMAL:  cur = head.cur_normal;
			btcc_pkg::ST_REDUCED: cur = head.cur_reduced;
			default:              cur = head.cur_stopped;
		endcase

		res_nx.charge_state       = state_nx;
		res_nx.change_code        = code;
		res_nx.update_req         = plug || (cur != last_cur_q);
		res_nx.disable_charge     = state_nx == btcc_pkg::ST_STOPPED;
		res_nx.current_ma         = cur;
		res_nx.pseudo_charging_ui = pseudo_nx;
		if (head.band == btcc_pkg::BAND_ABOVE) begin
			res_nx.health = btcc_pkg::HEALTH_OVERHEAT;
		end else if (head.band == btcc_pkg::BAND_COLD) begin
			res_nx.health = btcc_pkg::HEALTH_COLD;
		end else begin
			res_nx.health = btcc_pkg::HEALTH_GOOD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= btcc_pkg::ST_NORMAL;
			pseudo_q    <= 1'b0;
			last_chg_q  <= 1'b0;
			last_cur_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				state_q     <= state_nx;
				pseudo_q    <= pseudo_nx;
				last_chg_q  <= head.charger;
				last_cur_q  <= cur;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_nx;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/btcc_checker.sv
// Port-level checks for battery_thermal_charge_control, bound to the top.
// Depends on btcc_pkg and the top level's port names.
`default_nettype none

module btcc_checker (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               out_valid,
	input wire                               out_ready,
	input wire logic [1:0]                   charge_state,
	input wire logic [2:0]                   change_code,
	input wire                               disable_charge,
	input wire logic [btcc_pkg::CUR_W-1:0]   current_ma,
	input wire logic [1:0]                   health,
	input wire                               pseudo_charging_ui
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(current_ma) &&
			$stable(charge_state) && $stable(change_code))
		else $error("result changed while stalled");

	a_disable_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> disable_charge == (charge_state == btcc_pkg::ST_STOPPED))
		else $error("disable_charge disagrees with charge_state");

	a_bad_health_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (health == btcc_pkg::HEALTH_OVERHEAT ||
			health == btcc_pkg::HEALTH_COLD) |-> charge_state == btcc_pkg::ST_STOPPED)
		else $error("charging not stopped at overheat or cold");

	a_code_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (change_code == btcc_pkg::CODE_STOP_NORMAL ||
			change_code == btcc_pkg::CODE_REDUCED_NORMAL) |->
			charge_state == btcc_pkg::ST_NORMAL && !pseudo_charging_ui)
		else $error("return to normal with wrong state or pseudo flag");

endmodule

bind battery_thermal_charge_control btcc_checker u_btcc_checker (.*);

`default_nettype wire

FILE: test/tb_battery_thermal_charge_control.sv
// Testbench for battery_thermal_charge_control: directed and random monitor ticks
// under several register settings, each result checked against a local predictor.
// Depends on btcc_pkg and the battery_thermal_charge_control top level.
`timescale 1ns / 100ps

module tb_battery_thermal_charge_control;
	import btcc_pkg::*;

	typedef struct {
		logic                      charger;
		logic signed [TEMP_W-1:0]  temp;
		logic [VOLT_W-1:0]         volt;
		logic [CUR_W-1:0]          therm;
		logic [CUR_W-1:0]          limit;
	} tick_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      charger_present = 1'b0;
	logic signed [TEMP_W-1:0]  battery_temp_c = '0;
	logic [VOLT_W-1:0]         battery_volt_uv = '0;
	logic [CUR_W-1:0]          thermal_limit_ma = '0;
	logic [CUR_W-1:0]          charger_limit_ma = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [1:0]                charge_state;
	logic [2:0]                change_code;
	logic                      update_req;
	logic                      disable_charge;
	logic [CUR_W-1:0]          current_ma;
	logic [1:0]                health;
	logic                      pseudo_charging_ui;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;

	// register shadow
	logic signed [TEMP_W-1:0]  bound_c [0:4] = '{RST_COLD_STOP_MAX, RST_COOL_MAX,
		RST_NORMAL_MAX, RST_WARM_MAX, RST_HOT_MAX};
	logic [VOLT_W-1:0]         volt_limit = RST_HOT_VOLT;
	logic [CUR_W-1:0]          cap_reduced = RST_REDUCED_CUR;
	logic [CUR_W-1:0]          cur_default = RST_DEFAULT_CUR;

	// predicted controller state
	mode_t                     p_mode = ST_NORMAL;
	logic                      p_pseudo = 1'b0;
	logic                      p_charger = 1'b0;
	logic [CUR_W-1:0]          p_current = '0;

	res_t due_results [$];

	int fail_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int settings_applied = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int recv_stall = 0;
	int walk_temp = 25;
	logic walk_chg = 1'b1;

	battery_thermal_charge_control dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.charger_present(charger_present),
		.battery_temp_c(battery_temp_c),
		.battery_volt_uv(battery_volt_uv),
		.thermal_limit_ma(thermal_limit_ma),
		.charger_limit_ma(charger_limit_ma),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.charge_state(charge_state),
		.change_code(change_code),
		.update_req(update_req),
		.disable_charge(disable_charge),
		.current_ma(current_ma),
		.health(health),
		.pseudo_charging_ui(pseudo_charging_ui),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int clamp(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int draw_wait(int pct);
		if ($urandom_range(99) < pct) return $urandom_range(16, 1);
		return 0;
	endfunction

	function automatic band_t band_of(input logic signed [TEMP_W-1:0] t);
		if (t > bound_c[4]) return BAND_ABOVE;
		if (t > bound_c[3]) return BAND_HOT;
		if (t > bound_c[2]) return BAND_WARM;
		if (t > bound_c[1]) return BAND_NORMAL;
		if (t > bound_c[0]) return BAND_COOL;
		return BAND_COLD;
	endfunction

	function automatic res_t predict_tick(input tick_t k);
		res_t r;
		band_t b;
		logic vhigh;
		logic frc;
		logic [2:0] code;
		logic [CUR_W-1:0] cur;
		frc = 1'b0;
		code = CODE_NONE;
		vhigh = k.volt > volt_limit;
		if (k.charger != p_charger) begin
			p_charger = k.charger;
			if (k.charger) begin
				p_mode = ST_NORMAL;
				frc = 1'b1;
			end
		end
		b = band_of(k.temp);
		case (p_mode)
			ST_NORMAL: begin
				if (b == BAND_ABOVE || b == BAND_COLD) begin
					code = CODE_NORMAL_STOP;
					p_pseudo = (b == BAND_COLD);
					p_mode = ST_STOPPED;
				end else if (b == BAND_HOT) begin
					if (vhigh) begin
						code = CODE_NORMAL_STOP;
						p_pseudo = 1'b1;
						p_mode = ST_STOPPED;
					end else begin
						code = CODE_NORMAL_REDUCED;
						p_pseudo = 1'b0;
						p_mode = ST_REDUCED;
					end
				end
			end
			ST_REDUCED: begin
				if (b == BAND_ABOVE || b == BAND_COLD) begin
					code = CODE_REDUCED_STOP;
					p_pseudo = (b == BAND_COLD);
					p_mode = ST_STOPPED;
				end else if (b <= BAND_NORMAL) begin
					code = CODE_REDUCED_NORMAL;
					p_pseudo = 1'b0;
					p_mode = ST_NORMAL;
				end else if (vhigh) begin
					code = CODE_REDUCED_STOP;
					p_pseudo = 1'b1;
					p_mode = ST_STOPPED;
				end
			end
			ST_STOPPED: begin
				if (b == BAND_NORMAL) begin
					code = CODE_STOP_NORMAL;
					p_pseudo = 1'b0;
					p_mode = ST_NORMAL;
				end else if (b == BAND_ABOVE) begin
					p_pseudo = 1'b0;
				end
			end
			default: ;
		endcase
		if (p_mode == ST_NORMAL)
			cur = (k.therm <= k.limit) ? k.therm : k.limit;
		else if (p_mode == ST_REDUCED)
			cur = (k.therm <= cap_reduced) ? k.therm : cap_reduced;
		else
			cur = cur_default;
		if (cur != p_current) begin
			p_current = cur;
			frc = 1'b1;
		end
		r.charge_state = p_mode;
		r.change_code = code;
		r.update_req = frc;
		r.disable_charge = (p_mode == ST_STOPPED);
		r.current_ma = cur;
		r.health = (b == BAND_ABOVE) ? HEALTH_OVERHEAT :
			(b == BAND_COLD) ? HEALTH_COLD : HEALTH_GOOD;
		r.pseudo_charging_ui = p_pseudo;
		return r;
	endfunction

	task automatic note_mismatch(input string msg);
		$display("MISMATCH: %s", msg);
		fail_count++;
	endtask

	task automatic cmp_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			note_mismatch($sformatf("result %0d %s: got %0d expected %0d",
				results_seen, name, got, want));
	endtask

	task automatic check_result();
		res_t want;
		if (due_results.size() == 0) begin
			note_mismatch($sformatf("result %0d arrived with no pending tick", results_seen));
		end else begin
			want = due_results.pop_front();
			cmp_field("charge_state", charge_state, want.charge_state);
			cmp_field("change_code", change_code, want.change_code);
			cmp_field("update_req", update_req, want.update_req);
			cmp_field("disable_charge", disable_charge, want.disable_charge);
			cmp_field("current_ma", current_ma, want.current_ma);
			cmp_field("health", health, want.health);
			cmp_field("pseudo_charging_ui", pseudo_charging_ui, want.pseudo_charging_ui);
		end
		results_seen++;
	endtask

	// result side: random stall drawn after each transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				check_result();
				recv_stall = draw_wait(recv_idle_pct);
			end
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_tick(input tick_t k);
		int gap;
		gap = draw_wait(send_idle_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		charger_present <= k.charger;
		battery_temp_c <= k.temp;
		battery_volt_uv <= k.volt;
		thermal_limit_ma <= k.therm;
		charger_limit_ma <= k.limit;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		due_results.push_back(predict_tick(k));
		items_sent++;
	endtask

	task automatic tk(input logic chg, input logic signed [TEMP_W-1:0] t,
			input logic [VOLT_W-1:0] v, input logic [CUR_W-1:0] te,
			input logic [CUR_W-1:0] cl);
		tick_t k;
		k.charger = chg;
		k.temp = t;
		k.volt = v;
		k.therm = te;
		k.limit = cl;
		send_tick(k);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_COLD_STOP_MAX: bound_c[0] = data[TEMP_W-1:0];
			CFG_COOL_MAX:      bound_c[1] = data[TEMP_W-1:0];
			CFG_NORMAL_MAX:    bound_c[2] = data[TEMP_W-1:0];
			CFG_WARM_MAX:      bound_c[3] = data[TEMP_W-1:0];
			CFG_HOT_MAX:       bound_c[4] = data[TEMP_W-1:0];
			CFG_HOT_VOLT:      volt_limit = data[VOLT_W-1:0];
			CFG_REDUCED_CUR:   cap_reduced = data[CUR_W-1:0];
			CFG_DEFAULT_CUR:   cur_default = data[CUR_W-1:0];
			default: ;
		endcase
	endtask

	// unused upper data bits carry junk; the block must ignore them
	task automatic apply_setting(input logic signed [TEMP_W-1:0] c0, c1, c2, c3, c4,
			input logic [VOLT_W-1:0] vl, input logic [CUR_W-1:0] rc, dc);
		drain_results();
		write_reg(CFG_COLD_STOP_MAX, {15'($urandom), c0});
		write_reg(CFG_COOL_MAX, {15'($urandom), c1});
		write_reg(CFG_NORMAL_MAX, {15'($urandom), c2});
		write_reg(CFG_WARM_MAX, {15'($urandom), c3});
		write_reg(CFG_HOT_MAX, {15'($urandom), c4});
		write_reg(CFG_HOT_VOLT, vl);
		write_reg(CFG_REDUCED_CUR, {11'($urandom), rc});
		write_reg(CFG_DEFAULT_CUR, {11'($urandom), dc});
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	task automatic random_setting(input bit ordered);
		int e [0:4];
		logic [VOLT_W-1:0] vl;
		if (ordered) begin
			e[0] = int'($urandom_range(60)) - 60;
			for (int i = 1; i < 5; i++)
				e[i] = clamp(e[i-1] + int'($urandom_range(25)), -128, 127);
		end else begin
			for (int i = 0; i < 5; i++)
				e[i] = int'($urandom_range(255)) - 128;
		end
		if ($urandom_range(3) == 0)
			vl = VOLT_W'($urandom_range(8388607));
		else
			vl = VOLT_W'(3500000 + $urandom_range(900000));
		apply_setting(TEMP_W'(e[0]), TEMP_W'(e[1]), TEMP_W'(e[2]), TEMP_W'(e[3]),
			TEMP_W'(e[4]), vl, CUR_W'($urandom_range(4095)), CUR_W'($urandom_range(4095)));
	endtask

	task automatic pick_idle();
		case ($urandom_range(3))
			0: send_idle_pct = 0;
			1: send_idle_pct = 20;
			2: send_idle_pct = 60;
			default: send_idle_pct = 100;
		endcase
		case ($urandom_range(3))
			0: recv_idle_pct = 0;
			1: recv_idle_pct = 20;
			2: recv_idle_pct = 60;
			default: recv_idle_pct = 100;
		endcase
	endtask

	// temperature walks across band edges so the state machine keeps moving
	task automatic run_random_ticks(input int n);
		tick_t k;
		int r;
		int t;
		int v;
		int c;
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0) pick_idle();
			if ($urandom_range(99) < 6) walk_chg = ~walk_chg;
			k.charger = walk_chg;
			r = $urandom_range(99);
			if (r < 40)
				t = int'(bound_c[$urandom_range(4)]) + int'($urandom_range(2)) - 1;
			else if (r < 85)
				t = walk_temp + int'($urandom_range(6)) - 3;
			else
				t = int'($urandom_range(255)) - 128;
			t = clamp(t, -128, 127);
			walk_temp = t;
			k.temp = TEMP_W'(t);
			r = $urandom_range(99);
			if (r < 40)
				v = clamp(int'(volt_limit) + int'($urandom_range(2)) - 1, 0, 8388607);
			else if (r < 70)
				v = $urandom_range(8388607);
			else
				v = 3000000 + $urandom_range(1500000);
			k.volt = VOLT_W'(v);
			r = $urandom_range(99);
			if (r < 15)
				c = clamp(int'(cap_reduced) + int'($urandom_range(2)) - 1, 0, 4095);
			else if (r < 25)
				c = $urandom_range(1) ? 4095 : 0;
			else
				c = $urandom_range(4095);
			k.therm = CUR_W'(c);
			r = $urandom_range(99);
			if (r < 20)
				k.limit = k.therm;
			else if (r < 30)
				k.limit = $urandom_range(1) ? CUR_W'(4095) : CUR_W'(0);
			else
				k.limit = CUR_W'($urandom_range(4095));
			send_tick(k);
			if (i % 100 == 99) drain_results();
		end
	endtask

	task automatic test_directed_transitions();
		send_idle_pct = 50;
		recv_idle_pct = 50;
		tk(1, 25, 3700000, 1500, 2000);
		tk(1, 25, 3700000, 0, 4095);
		tk(1, 42, 3700000, 4095, 4095);
		tk(1, 46, 4000000, 800, 4095);     // at the voltage limit: reduce
		tk(1, 45, 4000000, 300, 0);
		tk(1, 50, 4000001, 300, 0);        // hot and high voltage: stop
		tk(1, 30, 3700000, 2000, 1200);
		tk(1, -11, 0, 2000, 1200);         // too cold
		tk(1, -10, 0, 2000, 1200);
		tk(1, 56, 0, 2000, 1200);          // above hot while stopped
		tk(1, 55, 8388607, 2000, 1200);
		tk(1, -4, 8388607, 2000, 1200);
		tk(1, 46, 100, 4095, 4095);
		tk(1, -5, 100, 4095, 4095);        // cool band from reduced
		tk(1, 46, 0, 4095, 4095);
		tk(1, 127, 0, 4095, 4095);
		tk(0, 127, 0, 4095, 4095);         // charger removed
		tk(1, 127, 0, 4095, 4095);         // plug-in
		tk(1, 20, 0, 1234, 4095);
		tk(1, 46, 8388607, 1234, 4095);
		tk(0, -128, 0, 0, 0);
		tk(0, 20, 0, 0, 0);
		tk(0, -128, 0, 0, 0);
		tk(1, -6, 0, 4095, 0);
		tk(1, 0, 8388607, 4095, 4095);
	endtask

	task automatic test_config_extremes();
		apply_setting(-128, -128, -128, -128, -128, 0, 0, 0);
		run_random_ticks(50);
		apply_setting(127, 127, 127, 127, 127, 8388607, 4095, 4095);
		run_random_ticks(50);
		apply_setting(-128, -127, 125, 126, 127, 0, 4095, 0);
		run_random_ticks(50);
		apply_setting(127, 126, -126, -127, -128, 8388607, 0, 4095);
		run_random_ticks(50);
	endtask

	task automatic test_random_traffic();
		int eq;
		apply_setting(RST_COLD_STOP_MAX, RST_COOL_MAX, RST_NORMAL_MAX, RST_WARM_MAX,
			RST_HOT_MAX, RST_HOT_VOLT, RST_REDUCED_CUR, RST_DEFAULT_CUR);
		run_random_ticks(155);
		for (int s = 0; s < 3; s++) begin
			random_setting(1);
			run_random_ticks(155);
		end
		random_setting(0);
		run_random_ticks(155);
		eq = int'($urandom_range(80)) - 40;
		apply_setting(TEMP_W'(eq), TEMP_W'(eq), TEMP_W'(eq), TEMP_W'(eq), TEMP_W'(eq),
			VOLT_W'($urandom_range(8388607)),
			CUR_W'($urandom_range(4095)), CUR_W'($urandom_range(4095)));
		run_random_ticks(155);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_transitions();
		test_config_extremes();
		test_random_traffic();
		drain_results();
		repeat (4) @(posedge clk);
		if (due_results.size() != 0)
			note_mismatch($sformatf("%0d expected results never arrived",
				due_results.size()));
		$display("Ran %0d ticks across %0d register settings; %0d results checked.",
			items_sent, settings_applied, results_seen);
		$display("Covered all band edges, state changes, plug and unplug, random stalls.");
		if (fail_count == 0)
			$display("tb_battery_thermal_charge_control passed");
		else
			$display("tb_battery_thermal_charge_control failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("timeout with %0d results outstanding", due_results.size());
		$display("tb_battery_thermal_charge_control failed");
		$finish;
	end

endmodule

FILE: battery_thermal_charge_control.f
hdl/btcc_pkg.sv
hdl/btcc_front.sv
hdl/btcc_queue.sv
hdl/btcc_back.sv
hdl/battery_thermal_charge_control.sv
hdl/btcc_checker.sv
test/tb_battery_thermal_charge_control.sv
